### src/x25_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x25_pkg
// Shared types, field constants and the ladder microcode for the X25519 core.
// ----------------------------------------------------------------------------
package x25_pkg;

	localparam int FE_W      = 256;
	localparam int DIGIT_W   = 8;
	localparam int RAW_W     = FE_W + 3;
	localparam int PROD_W    = FE_W + DIGIT_W;
	localparam int SLOT_N    = 16;
	localparam int WORD_W    = 64;

	typedef logic [FE_W-1:0] fe_t;

	localparam fe_t FE_P = 256'h7fffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffff_ffffffed;
	localparam logic [RAW_W-1:0] FE_4P = {1'b0, FE_P, 2'b00};
	localparam fe_t FE_ONE = 256'd1;
	localparam fe_t FE_NINE = 256'd9;
	localparam fe_t FE_A24 = 256'd121666;

	localparam logic [4:0] MUL_LAST     = 5'(FE_W / DIGIT_W - 1);
	localparam logic [7:0] LADDER_LAST  = 8'd254;
	localparam logic [7:0] INV_TOP      = 8'd254;
	localparam logic [7:0] INV_SKIP_A   = 8'd2;
	localparam logic [7:0] INV_SKIP_B   = 8'd4;
	localparam logic [2:0] INIT_LAST    = 3'd6;

	localparam logic [4:0] PC_LAST_STEP = 5'd17;
	localparam logic [4:0] PC_SQ        = 5'd18;
	localparam logic [4:0] PC_MULZ      = 5'd19;
	localparam logic [4:0] PC_FIN       = 5'd20;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} alu_op_t;

	typedef enum logic [3:0] {
		S_X1, S_X2, S_Z2, S_X3, S_Z3, S_A, S_AA, S_B,
		S_BB, S_E, S_C, S_D, S_DA, S_CB, S_K, S_T
	} slot_t;

	typedef struct packed {
		alu_op_t op;
		slot_t   dst;
		slot_t   src_a;
		slot_t   src_b;
	} uop_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ctrl_sts_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_INIT,
		C_RD,
		C_LD,
		C_EXEC,
		C_CANON,
		C_DONE
	} ctrl_state_t;

	function automatic uop_t uop_rom(input logic [4:0] pc);
		uop_t u;
		unique case (pc)
			5'd0:    u = '{OP_ADD, S_A,  S_X2, S_Z2};
			5'd1:    u = '{OP_MUL, S_AA, S_A,  S_A};
			5'd2:    u = '{OP_SUB, S_B,  S_X2, S_Z2};
			5'd3:    u = '{OP_MUL, S_BB, S_B,  S_B};
			5'd4:    u = '{OP_SUB, S_E,  S_AA, S_BB};
			5'd5:    u = '{OP_ADD, S_C,  S_X3, S_Z3};
			5'd6:    u = '{OP_SUB, S_D,  S_X3, S_Z3};
			5'd7:    u = '{OP_MUL, S_DA, S_D,  S_A};
			5'd8:    u = '{OP_MUL, S_CB, S_C,  S_B};
			5'd9:    u = '{OP_ADD, S_X3, S_DA, S_CB};
			5'd10:   u = '{OP_MUL, S_X3, S_X3, S_X3};
			5'd11:   u = '{OP_SUB, S_Z3, S_DA, S_CB};
			5'd12:   u = '{OP_MUL, S_Z3, S_Z3, S_Z3};
			5'd13:   u = '{OP_MUL, S_Z3, S_Z3, S_X1};
			5'd14:   u = '{OP_MUL, S_X2, S_AA, S_BB};
			5'd15:   u = '{OP_MUL, S_Z2, S_E,  S_K};
			5'd16:   u = '{OP_ADD, S_Z2, S_Z2, S_BB};
			5'd17:   u = '{OP_MUL, S_Z2, S_Z2, S_E};
			5'd18:   u = '{OP_MUL, S_T,  S_T,  S_T};
			5'd19:   u = '{OP_MUL, S_T,  S_T,  S_Z2};
			5'd20:   u = '{OP_MUL, S_X2, S_X2, S_T};
			default: u = '{OP_ADD, S_A,  S_X2, S_Z2};
		endcase
		return u;
	endfunction

	// ladder swap by address: x2/x3 and z2/z3 trade places
	function automatic slot_t map_slot(input slot_t s, input logic sw);
		slot_t m;
		m = s;
		if (sw) begin
			unique case (s)
				S_X2:    m = S_X3;
				S_X3:    m = S_X2;
				S_Z2:    m = S_Z3;
				S_Z3:    m = S_Z2;
				default: m = s;
			endcase
		end
		return m;
	endfunction

endpackage
`default_nettype wire

### src/x25_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x25_req_if
// Input channel: one scalar word and one point word per beat.
// ----------------------------------------------------------------------------
interface x25_req_if;
	logic        valid;
	logic        ready;
	logic [63:0] scalar_word;
	logic [63:0] point_word;
	logic [1:0]  word_index;
	logic        use_base_point;

	modport source(output valid, scalar_word, point_word, word_index, use_base_point,
		input ready);
	modport sink(input valid, scalar_word, point_word, word_index, use_base_point,
		output ready);
endinterface
`default_nettype wire

### src/x25_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x25_rsp_if
// Output channel: one result word per beat.
// ----------------------------------------------------------------------------
interface x25_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_word;
	logic [1:0]  result_index;
	logic        last_word;
	logic        result_all_zero;

	modport source(output valid, result_word, result_index, last_word, result_all_zero,
		input ready);
	modport sink(input valid, result_word, result_index, last_word, result_all_zero,
		output ready);
endinterface
`default_nettype wire

### src/x25_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x25_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module x25_ram #(
	parameter int WIDTH = 256,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule
`default_nettype wire

### src/x25_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x25_alu
// GF(2^255-19) add, subtract and digit-serial multiply (8 bits per cycle,
// most significant digit first). Results stay below 2^256, not canonical.
// ----------------------------------------------------------------------------
module x25_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire x25_pkg::alu_req_t req,
	input  wire x25_pkg::fe_t      a,
	input  wire x25_pkg::fe_t      b,
	output x25_pkg::fe_t           res,
	output logic                   done
);
	import x25_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [4:0]          cnt_q;
	alu_op_t             op_q;
	fe_t                 acc_q;
	fe_t                 ash_q;
	fe_t                 b_q;
	logic [RAW_W-1:0]    raw_q;
	logic [RAW_W-1:0]    raw_d;
	logic [DIGIT_W-1:0]  digit;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     sum;
	fe_t                 mul_next;
	fe_t                 small_next;

	assign digit = ash_q[FE_W-1 -: DIGIT_W];
	assign prod  = PROD_W'(digit) * PROD_W'(b_q);
	assign sum   = {1'b0, acc_q, {DIGIT_W{1'b0}}} + {1'b0, prod};
	assign mul_next = FE_W'(sum[FE_W-2:0]) + FE_W'(15'(sum[PROD_W:FE_W-1]) * 15'd19);
	assign small_next = FE_W'(raw_q[FE_W-2:0]) + FE_W'(9'(raw_q[RAW_W-1:FE_W-1]) * 9'd19);

	always_comb begin
		if (req.op == OP_ADD) begin
			raw_d = {3'b000, a} + {3'b000, b};
		end else begin
			raw_d = {3'b000, a} + FE_4P - {3'b000, b};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_ADD;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				if (op_q != OP_MUL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == MUL_LAST) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			ash_q <= a;
			b_q   <= b;
			raw_q <= raw_d;
		end else if (busy_q) begin
			if (op_q != OP_MUL) begin
				acc_q <= small_next;
			end else begin
				acc_q <= mul_next;
				ash_q <= {ash_q[FE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			end
		end
	end

	assign res  = acc_q;
	assign done = done_q;
endmodule
`default_nettype wire

### src/x25_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x25_ctrl
// Ladder and inversion sequencer: steps the microcode over the slot RAM and
// the field ALU, then reduces the product to its canonical value.
// ----------------------------------------------------------------------------
module x25_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [254:0]  scalar,
	input  wire x25_pkg::fe_t  point,
	output x25_pkg::ctrl_sts_t sts,
	output x25_pkg::fe_t       result
);
	import x25_pkg::*;

	ctrl_state_t  state_q, state_d;
	logic [4:0]   pc_q;
	logic [7:0]   step_q;
	logic [7:0]   inv_q;
	logic [2:0]   init_q;
	logic [254:0] k_q;
	fe_t          pt_q;
	fe_t          res_q;

	uop_t         uop;
	logic         cur_bit;
	slot_t        ra, rb, wa, init_slot;
	fe_t          init_val;
	logic         we;
	slot_t        waddr;
	fe_t          wdata;
	fe_t          rd_a, rd_b;
	alu_req_t     alu_req;
	fe_t          alu_res;
	logic         alu_done;
	logic         op_done;
	logic         step_end;

	assign uop     = uop_rom(pc_q);
	assign cur_bit = k_q[254] & (pc_q <= PC_LAST_STEP);
	assign ra      = map_slot(uop.src_a, cur_bit);
	assign rb      = map_slot(uop.src_b, cur_bit);
	assign wa      = map_slot(uop.dst, cur_bit);
	assign op_done = (state_q == C_EXEC) && alu_done;
	assign step_end = op_done && (pc_q == PC_LAST_STEP) && (step_q != LADDER_LAST);

	always_comb begin
		unique case (init_q)
			3'd0:    begin init_slot = S_X1; init_val = pt_q;   end
			3'd1:    begin init_slot = S_X2; init_val = FE_ONE; end
			3'd2:    begin init_slot = S_Z2; init_val = '0;     end
			3'd3:    begin init_slot = S_X3; init_val = pt_q;   end
			3'd4:    begin init_slot = S_Z3; init_val = FE_ONE; end
			3'd5:    begin init_slot = S_K;  init_val = FE_A24; end
			default: begin init_slot = S_T;  init_val = FE_ONE; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		we            = 1'b0;
		waddr         = wa;
		wdata         = alu_res;
		alu_req.start = 1'b0;
		alu_req.op    = uop.op;
		sts.busy      = (state_q != C_IDLE);
		sts.done      = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					state_d = C_INIT;
				end
			end
			C_INIT: begin
				we    = 1'b1;
				waddr = init_slot;
				wdata = init_val;
				if (init_q == INIT_LAST) begin
					state_d = C_RD;
				end
			end
			C_RD: begin
				state_d = C_LD;
			end
			C_LD: begin
				alu_req.start = 1'b1;
				state_d       = C_EXEC;
			end
			C_EXEC: begin
				if (alu_done) begin
					if (pc_q == PC_FIN) begin
						state_d = C_CANON;
					end else begin
						we      = 1'b1;
						state_d = C_RD;
					end
				end
			end
			C_CANON: begin
				state_d = C_DONE;
			end
			C_DONE: begin
				sts.done = 1'b1;
				state_d  = C_IDLE;
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	// microcode counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			step_q <= '0;
			inv_q  <= '0;
			init_q <= '0;
		end else begin
			if (state_q == C_IDLE) begin
				init_q <= '0;
				pc_q   <= '0;
				step_q <= '0;
			end else if (state_q == C_INIT) begin
				init_q <= init_q + 3'd1;
			end else if (op_done) begin
				priority if (pc_q < PC_LAST_STEP) begin
					pc_q <= pc_q + 5'd1;
				end else if (pc_q == PC_LAST_STEP) begin
					if (step_q == LADDER_LAST) begin
						pc_q  <= PC_SQ;
						inv_q <= INV_TOP;
					end else begin
						pc_q   <= '0;
						step_q <= step_q + 8'd1;
					end
				end else if (pc_q == PC_SQ) begin
					if (inv_q != INV_SKIP_A && inv_q != INV_SKIP_B) begin
						pc_q <= PC_MULZ;
					end else if (inv_q == '0) begin
						pc_q <= PC_FIN;
					end else begin
						inv_q <= inv_q - 8'd1;
					end
				end else if (pc_q == PC_MULZ) begin
					if (inv_q == '0) begin
						pc_q <= PC_FIN;
					end else begin
						inv_q <= inv_q - 8'd1;
						pc_q  <= PC_SQ;
					end
				end else begin
					pc_q <= pc_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			k_q  <= scalar;
			pt_q <= point;
		end else if (step_end) begin
			k_q <= {k_q[253:0], 1'b0};
		end
		if (op_done && pc_q == PC_FIN) begin
			res_q <= alu_res;
		end else if (state_q == C_CANON) begin
			res_q <= (res_q >= FE_P) ? res_q - FE_P : res_q;
		end
	end

	x25_ram #(
		.WIDTH(FE_W),
		.DEPTH(SLOT_N)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(ra),
		.raddr_b(rb),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	x25_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (rd_a),
		.b     (rd_b),
		.res   (alu_res),
		.done  (alu_done)
	);

	assign result = res_q;
endmodule
`default_nettype wire

### src/x25519_scalar_multiply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// x25519_scalar_multiply
// X25519 scalar multiplication with a Montgomery ladder over GF(2^255-19).
// ----------------------------------------------------------------------------
// Load the scalar and the u-coordinate as four beats, word index 0 to 3; the
// beat with index 3 starts a run and its use_base_point selects u = 9. One run
// runs 255 ladder steps of ten field products and eight add/sub operations,
// then 508 products for the inversion, all on a single multiplier that takes
// 8 bits of one operand per cycle; each operation also passes through operand
// fetch and write back. Four result beats follow; the input is not ready until
// the last of them has been taken.
module x25519_scalar_multiply (
	input  wire logic clk,
	input  wire logic arst_n,
	x25_req_if.sink   req,
	x25_rsp_if.source rsp
);
	import x25_pkg::*;

	logic [WORD_W-1:0] sw_q [3];
	logic [WORD_W-1:0] pw_q [3];
	logic              accept;
	logic              start;
	logic [FE_W-1:0]   scal;
	logic [254:0]      k_clamp;
	fe_t               point;
	ctrl_sts_t         sts;
	fe_t               result;
	fe_t               out_q;
	logic              zero_q;
	logic [1:0]        cnt_q;
	logic              active_q;

	assign req.ready = !sts.busy && !active_q;
	assign accept    = req.valid && req.ready;
	assign start     = accept && (req.word_index == 2'd3);

	assign scal    = {req.scalar_word, sw_q[2], sw_q[1], sw_q[0]};
	assign k_clamp = {1'b1, scal[253:3], 3'b000};
	assign point   = req.use_base_point ? FE_NINE
		: {1'b0, req.point_word[62:0], pw_q[2], pw_q[1], pw_q[0]};

	always_ff @(posedge clk) begin
		if (accept && req.word_index != 2'd3) begin
			sw_q[req.word_index] <= req.scalar_word;
			pw_q[req.word_index] <= req.point_word;
		end
	end

	x25_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.scalar(k_clamp),
		.point (point),
		.sts   (sts),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (sts.done) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (rsp.valid && rsp.ready) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// result leaves one word per beat
	always_ff @(posedge clk) begin
		if (sts.done) begin
			out_q  <= result;
			zero_q <= (result == '0);
		end else if (rsp.valid && rsp.ready) begin
			out_q <= {{WORD_W{1'b0}}, out_q[FE_W-1:WORD_W]};
		end
	end

	assign rsp.valid           = active_q;
	assign rsp.result_word     = out_q[WORD_W-1:0];
	assign rsp.result_index    = cnt_q;
	assign rsp.last_word       = (cnt_q == 2'd3);
	assign rsp.result_all_zero = zero_q;
endmodule
`default_nettype wire

### sim/x25519_scalar_multiply_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x25519_scalar_multiply_tb
// Loads scalar and point words, predicts each X25519 result in field
// arithmetic mod 2^255-19, and checks every result beat in order. A directed
// table comes first, then random load sequences with random stalls on both
// channels, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module x25519_scalar_multiply_tb;
	import x25_pkg::*;

	typedef struct {
		logic [63:0] w;
		logic [1:0]  idx;
		logic        last;
		logic        zero;
	} result_beat_t;

	typedef struct {
		logic [63:0] scalar;
		logic [63:0] point;
		logic [1:0]  idx;
		logic        base;
		logic        typed_zero;
	} load_row_t;

	localparam int HOLD_CYCLES = 3000;
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 82;
	localparam int CALM_AFTER = 70;

	logic clk;
	logic arst_n;

	x25_req_if req_if();
	x25_rsp_if rsp_if();

	x25519_scalar_multiply u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	result_beat_t expected_q[$];
	logic [63:0] stored_scalar[4];
	logic [63:0] stored_point[4];
	load_row_t dir_rows[$];
	int mismatches;
	int idle_cycles;
	int sent;
	bit calm;
	bit hold_armed;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic fe_t fmul(input fe_t a, input fe_t b);
		logic [511:0] t;
		t = 512'(a) * 512'(b);
		return fe_t'(t % 512'(FE_P));
	endfunction

	function automatic fe_t fadd(input fe_t a, input fe_t b);
		logic [256:0] s;
		s = 257'(a) + 257'(b);
		if (s >= 257'(FE_P)) begin
			s = s - 257'(FE_P);
		end
		return fe_t'(s);
	endfunction

	function automatic fe_t fsub(input fe_t a, input fe_t b);
		if (a >= b) begin
			return a - b;
		end
		return fe_t'(257'(a) + 257'(FE_P) - 257'(b));
	endfunction

	function automatic fe_t x25519_ladder(input fe_t k_in, input fe_t u_in);
		fe_t k, x1, x2, z2, x3, z3, a, aa, b, bb, e, c, d, da, cb, t, inv;
		logic sw, bit_k;
		k = k_in;
		k[2:0] = 3'b000;
		k[255] = 1'b0;
		k[254] = 1'b1;
		x1 = u_in;
		x1[255] = 1'b0;
		x1 = x1 % FE_P;
		x2 = FE_ONE;
		z2 = '0;
		x3 = x1;
		z3 = FE_ONE;
		sw = 1'b0;
		for (int i = 254; i >= 0; i--) begin
			bit_k = k[i];
			if (sw ^ bit_k) begin
				t = x2; x2 = x3; x3 = t;
				t = z2; z2 = z3; z3 = t;
			end
			sw = bit_k;
			a = fadd(x2, z2);
			aa = fmul(a, a);
			b = fsub(x2, z2);
			bb = fmul(b, b);
			e = fsub(aa, bb);
			c = fadd(x3, z3);
			d = fsub(x3, z3);
			da = fmul(d, a);
			cb = fmul(c, b);
			x3 = fadd(da, cb);
			x3 = fmul(x3, x3);
			z3 = fsub(da, cb);
			z3 = fmul(z3, z3);
			z3 = fmul(z3, x1);
			x2 = fmul(aa, bb);
			z2 = fmul(e, FE_A24);
			z2 = fadd(z2, bb);
			z2 = fmul(z2, e);
		end
		if (sw) begin
			x2 = x3;
			z2 = z3;
		end
		inv = FE_ONE;
		for (int i = 254; i >= 0; i--) begin
			inv = fmul(inv, inv);
			if (i != 2 && i != 4) begin
				inv = fmul(inv, z2);
			end
		end
		return fmul(x2, inv);
	endfunction

	// store the words and queue the four result beats of a run
	task automatic store_and_predict(input load_row_t r);
		fe_t res;
		result_beat_t rb;
		stored_scalar[r.idx] = r.scalar;
		stored_point[r.idx] = r.point;
		if (r.idx == 2'd3) begin
			if (r.typed_zero) begin
				res = '0;
			end else begin
				res = x25519_ladder({stored_scalar[3], stored_scalar[2], stored_scalar[1],
					stored_scalar[0]}, r.base ? FE_NINE : {stored_point[3], stored_point[2],
					stored_point[1], stored_point[0]});
			end
			for (int i = 0; i < 4; i++) begin
				rb.w = res[64*i +: 64];
				rb.idx = 2'(i);
				rb.last = (i == 3);
				rb.zero = (res == '0);
				expected_q.push_back(rb);
			end
		end
	endtask

	task automatic send_word(input load_row_t r);
		int gap;
		if (!calm && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 12);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.scalar_word <= r.scalar;
		req_if.point_word <= r.point;
		req_if.word_index <= r.idx;
		req_if.use_base_point <= r.base;
		do @(posedge clk); while (!req_if.ready);
		store_and_predict(r);
		sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic drain();
		req_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// result checking
	always @(posedge clk) begin
		result_beat_t want;
		if (rsp_if.valid && rsp_if.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected beat: word %h index %0d", rsp_if.result_word,
						rsp_if.result_index);
				end
			end else begin
				want = expected_q.pop_front();
				if (rsp_if.result_word !== want.w || rsp_if.result_index !== want.idx ||
					rsp_if.last_word !== want.last || rsp_if.result_all_zero !== want.zero) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("beat mismatch: exp %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
							want.w, want.idx, want.last, want.zero, rsp_if.result_word,
							rsp_if.result_index, rsp_if.last_word, rsp_if.result_all_zero);
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("x25519_scalar_multiply: mismatch");
				$finish;
			end
		end
	end

	// output side stalls
	initial begin
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_armed && rsp_if.valid) begin
				hold_armed = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm || $urandom_range(0, 3) != 0) begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		load_row_t r;
		int kind;
		bit paused;
		mismatches = 0;
		idle_cycles = 0;
		sent = 0;
		calm = 1'b0;
		hold_armed = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.scalar_word = '0;
		req_if.point_word = '0;
		req_if.word_index = '0;
		req_if.use_base_point = 1'b0;

		// u = 0 gives zero
		for (int i = 0; i < 4; i++) begin
			dir_rows.push_back('{'1, '0, 2'(i), 1'b0, 1'b1});
		end
		// u = p is taken mod p, so zero again
		dir_rows.push_back('{'0, 64'hffffffff_ffffffed, 2'd0, 1'b0, 1'b0});
		dir_rows.push_back('{'0, '1, 2'd1, 1'b0, 1'b0});
		dir_rows.push_back('{'0, '1, 2'd2, 1'b0, 1'b1});
		dir_rows.push_back('{'0, 64'h7fffffff_ffffffff, 2'd3, 1'b0, 1'b1});
		// base point, point words still stored
		dir_rows.push_back('{64'h0123456789abcdef, '1, 2'd0, 1'b0, 1'b0});
		dir_rows.push_back('{64'hfedcba9876543210, '1, 2'd1, 1'b1, 1'b0});
		dir_rows.push_back('{64'h5555aaaa5555aaaa, '1, 2'd2, 1'b0, 1'b0});
		dir_rows.push_back('{64'haaaa5555aaaa5555, '1, 2'd3, 1'b1, 1'b0});
		// all ones point, masked and reduced
		dir_rows.push_back('{'1, '1, 2'd3, 1'b0, 1'b0});
		// out of order, rewrite of a word
		dir_rows.push_back('{64'h1, 64'h9, 2'd2, 1'b0, 1'b0});
		dir_rows.push_back('{64'h2, 64'h0, 2'd0, 1'b0, 1'b0});
		dir_rows.push_back('{64'h3, 64'h0, 2'd2, 1'b0, 1'b0});
		dir_rows.push_back('{64'h4, 64'h0, 2'd1, 1'b0, 1'b0});
		dir_rows.push_back('{64'h8000000000000000, 64'h0, 2'd3, 1'b0, 1'b0});
		dir_rows.push_back('{64'h7fffffffffffffff, 64'h1, 2'd3, 1'b1, 1'b0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i]);
		end
		drain();

		sent = 0;
		hold_armed = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= CALM_AFTER);
			if (!paused && sent >= 40) begin
				paused = 1'b1;
				drain();
			end
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				for (int i = 0; i < 4; i++) begin
					r = '{rand64(), rand64(), 2'(i), 1'($urandom_range(0, 1)), 1'b0};
					send_word(r);
				end
			end else begin
				r = '{rand64(), rand64(), 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), 1'b0};
				send_word(r);
			end
		end
		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("x25519_scalar_multiply: match");
		end else begin
			$display("x25519_scalar_multiply: mismatch");
		end
		$finish;
	end

endmodule

### x25519_scalar_multiply.f
src/x25_pkg.sv
src/x25_req_if.sv
src/x25_rsp_if.sv
src/x25_ram.sv
src/x25_alu.sv
src/x25_ctrl.sv
src/x25519_scalar_multiply.sv
sim/x25519_scalar_multiply_tb.sv
